>>> sv/stxrx_pkg.sv
package stxrx_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned LINE_W = 2;
  localparam int unsigned POS_W = 4;
  localparam int unsigned PHASE_W = 2;

  localparam logic [BYTE_W-1:0] START_CODE_RESET = 8'h02;
  localparam logic [BYTE_W-1:0] END_CODE_RESET = 8'h03;

  // register index, taken from paddr[2]
  localparam logic REG_START = 1'b0;
  localparam logic REG_END = 1'b1;

  localparam logic [PHASE_W-1:0] PH_HUNT = 2'd0;
  localparam logic [PHASE_W-1:0] PH_COLOR = 2'd1;
  localparam logic [PHASE_W-1:0] PH_TEXT = 2'd2;
  localparam logic [PHASE_W-1:0] PH_TERM = 2'd3;

  localparam logic [STATUS_W-1:0] ST_HUNT = 3'd0;
  localparam logic [STATUS_W-1:0] ST_RESTART = 3'd1;
  localparam logic [STATUS_W-1:0] ST_COLOR = 3'd2;
  localparam logic [STATUS_W-1:0] ST_CHAR = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DONE = 3'd4;
  localparam logic [STATUS_W-1:0] ST_ABORT = 3'd5;
  localparam logic [STATUS_W-1:0] ST_DROP = 3'd6;

  typedef struct packed {
    logic [BYTE_W-1:0] start_code;
    logic [BYTE_W-1:0] end_code;
  } cfg_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                char_write;
    logic [LINE_W-1:0]   line_number;
    logic [POS_W-1:0]    char_position;
    logic [BYTE_W-1:0]   char_value;
    logic [BYTE_W-1:0]   text_color;
  } res_t;

endpackage

>>> sv/stxrx_regs.sv
module stxrx_regs (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output stxrx_pkg::cfg_t    cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_code <= stxrx_pkg::START_CODE_RESET;
      cfg.end_code <= stxrx_pkg::END_CODE_RESET;
    end else if (wr_en) begin
      case (paddr[2])
        stxrx_pkg::REG_START: cfg.start_code <= pwdata[7:0];
        stxrx_pkg::REG_END: cfg.end_code <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      stxrx_pkg::REG_START: prdata = {24'd0, cfg.start_code};
      stxrx_pkg::REG_END: prdata = {24'd0, cfg.end_code};
      default: prdata = 32'd0;
    endcase
  end

endmodule

>>> sv/stxrx_step.sv
module stxrx_step #(
  parameter int unsigned CHARS_PER_LINE = 10,
  parameter int unsigned LINES = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  logic [7:0]      rx_byte,
  input  stxrx_pkg::cfg_t cfg,
  output stxrx_pkg::res_t res
);

  logic [1:0] phase, phase_next;
  logic [1:0] line_counter, line_counter_next;
  logic [3:0] position_counter, position_counter_next;
  logic [7:0] color_hold, color_hold_next;
  logic       is_start, is_end, pos_last, line_last;

  assign is_start = (rx_byte == cfg.start_code);
  assign is_end = (rx_byte == cfg.end_code);
  assign pos_last = ({1'b0, position_counter} + 5'd1) >= 5'(CHARS_PER_LINE);
  assign line_last = ({1'b0, line_counter} + 3'd1) >= 3'(LINES);

  always_comb begin
    phase_next = phase;
    line_counter_next = line_counter;
    position_counter_next = position_counter;
    color_hold_next = color_hold;
    res = '0;
    case (phase)
      stxrx_pkg::PH_HUNT: begin
        if (is_start) begin
          phase_next = stxrx_pkg::PH_COLOR;
          res.status = stxrx_pkg::ST_RESTART;
        end else begin
          res.status = stxrx_pkg::ST_HUNT;
        end
      end
      stxrx_pkg::PH_COLOR: begin
        if (is_start) begin
          res.status = stxrx_pkg::ST_RESTART;
        end else if (is_end) begin
          phase_next = stxrx_pkg::PH_HUNT;
          res.status = stxrx_pkg::ST_ABORT;
        end else begin
          color_hold_next = rx_byte;
          line_counter_next = '0;
          position_counter_next = '0;
          phase_next = stxrx_pkg::PH_TEXT;
          res.status = stxrx_pkg::ST_COLOR;
        end
      end
      stxrx_pkg::PH_TEXT: begin
        if (is_start) begin
          phase_next = stxrx_pkg::PH_COLOR;
          res.status = stxrx_pkg::ST_RESTART;
        end else if (is_end) begin
          phase_next = stxrx_pkg::PH_HUNT;
          res.status = stxrx_pkg::ST_ABORT;
        end else begin
          res.status = stxrx_pkg::ST_CHAR;
          res.char_write = 1'b1;
          res.line_number = line_counter;
          res.char_position = position_counter;
          res.char_value = rx_byte;
          if (pos_last) begin
            position_counter_next = '0;
            if (line_last) begin
              line_counter_next = '0;
              phase_next = stxrx_pkg::PH_TERM;
            end else begin
              line_counter_next = line_counter + 2'd1;
            end
          end else begin
            position_counter_next = position_counter + 4'd1;
          end
        end
      end
      default: begin
        if (is_start) begin
          phase_next = stxrx_pkg::PH_COLOR;
          res.status = stxrx_pkg::ST_RESTART;
        end else if (is_end) begin
          phase_next = stxrx_pkg::PH_HUNT;
          res.status = stxrx_pkg::ST_DONE;
        end else begin
          phase_next = stxrx_pkg::PH_HUNT;
          res.status = stxrx_pkg::ST_DROP;
        end
      end
    endcase
    res.text_color = color_hold_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= stxrx_pkg::PH_HUNT;
      line_counter <= '0;
      position_counter <= '0;
      color_hold <= '0;
    end else if (load) begin
      phase <= phase_next;
      line_counter <= line_counter_next;
      position_counter <= position_counter_next;
      color_hold <= color_hold_next;
    end
  end

endmodule

>>> sv/stx_etx_text_frame_receiver_core.sv
// channel   handshake               payload
// rx        rx_valid / rx_stall     rx_byte
// result    res_valid / res_stall   status, char_write, line_number, char_position,
//                                   char_value, text_color
// config    apb psel/penable        paddr, pwdata, prdata
//
// one byte per cycle sustained while res_stall is low; from accept to result a byte passes
// the input register then the result register, with the phase machine between them
// rst is synchronous: phase hunting, counters and color cleared, codes 2 and 3
// a held result stalls only the input register; rx_stall rises once both are full
module stx_etx_text_frame_receiver_core #(
  parameter int unsigned CHARS_PER_LINE = 10,
  parameter int unsigned LINES = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        rx_valid,
  output logic        rx_stall,
  input  logic [7:0]  rx_byte,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [2:0]  status,
  output logic        char_write,
  output logic [1:0]  line_number,
  output logic [3:0]  char_position,
  output logic [7:0]  char_value,
  output logic [7:0]  text_color
);

  stxrx_pkg::cfg_t cfg;
  stxrx_pkg::res_t step_res;
  stxrx_pkg::res_t res;
  logic            hold_valid;
  logic [7:0]      hold_byte;
  logic            load;

  stxrx_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  stxrx_step #(
    .CHARS_PER_LINE (CHARS_PER_LINE),
    .LINES          (LINES)
  ) u_step (
    .clk     (clk),
    .rst     (rst),
    .load    (load),
    .rx_byte (hold_byte),
    .cfg     (cfg),
    .res     (step_res)
  );

  assign load = hold_valid && (!res_valid || !res_stall);
  assign rx_stall = hold_valid && !load;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (rx_valid && !rx_stall) begin
      hold_valid <= 1'b1;
    end else if (load) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_valid && !rx_stall) begin
      hold_byte <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= step_res;
    end
  end

  assign status = res.status;
  assign char_write = res.char_write;
  assign line_number = res.line_number;
  assign char_position = res.char_position;
  assign char_value = res.char_value;
  assign text_color = res.text_color;

endmodule

>>> verif/stx_etx_text_frame_receiver_core_tb.sv
module stx_etx_text_frame_receiver_core_tb;

  localparam int unsigned CHARS_PER_LINE = 10;
  localparam int unsigned LINES = 4;
  localparam int unsigned FRAME_CHARS = CHARS_PER_LINE * LINES;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 10;
  localparam int MAX_REPORTS = 10;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        rx_valid = 1'b0;
  logic        rx_stall;
  logic [7:0]  rx_byte = '0;
  logic        res_valid;
  logic        res_stall = 1'b0;
  logic [2:0]  status;
  logic        char_write;
  logic [1:0]  line_number;
  logic [3:0]  char_position;
  logic [7:0]  char_value;
  logic [7:0]  text_color;

  stx_etx_text_frame_receiver_core #(
    .CHARS_PER_LINE(CHARS_PER_LINE),
    .LINES(LINES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .rx_valid(rx_valid),
    .rx_stall(rx_stall),
    .rx_byte(rx_byte),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .status(status),
    .char_write(char_write),
    .line_number(line_number),
    .char_position(char_position),
    .char_value(char_value),
    .text_color(text_color)
  );

  always #5 clk = ~clk;

  // frame decoder copy
  logic [7:0] cur_start = stxrx_pkg::START_CODE_RESET;
  logic [7:0] cur_end = stxrx_pkg::END_CODE_RESET;
  logic [1:0] rx_phase = stxrx_pkg::PH_HUNT;
  logic [1:0] line_cnt = '0;
  logic [3:0] pos_cnt = '0;
  logic [7:0] color_hold = '0;

  logic [7:0]      rx_bytes_pending[$];
  stxrx_pkg::res_t expected_results[$];
  stxrx_pkg::res_t got_res;
  stxrx_pkg::res_t want_res;

  int errors = 0;
  int phase_items = 0;
  int tx_gap = 0;
  int tx_burst = 0;
  int rx_gap = 0;
  int rx_burst = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int idle_cycles = 0;

  function automatic stxrx_pkg::res_t decode_byte(input logic [7:0] b);
    stxrx_pkg::res_t r;
    logic is_start;
    logic is_end;
    r = '0;
    is_start = (b == cur_start);
    is_end = (b == cur_end);
    case (rx_phase)
      stxrx_pkg::PH_HUNT: begin
        if (is_start) begin
          rx_phase = stxrx_pkg::PH_COLOR;
          r.status = stxrx_pkg::ST_RESTART;
        end else begin
          r.status = stxrx_pkg::ST_HUNT;
        end
      end
      stxrx_pkg::PH_COLOR: begin
        if (is_start) begin
          r.status = stxrx_pkg::ST_RESTART;
        end else if (is_end) begin
          rx_phase = stxrx_pkg::PH_HUNT;
          r.status = stxrx_pkg::ST_ABORT;
        end else begin
          color_hold = b;
          line_cnt = '0;
          pos_cnt = '0;
          rx_phase = stxrx_pkg::PH_TEXT;
          r.status = stxrx_pkg::ST_COLOR;
        end
      end
      stxrx_pkg::PH_TEXT: begin
        if (is_start) begin
          rx_phase = stxrx_pkg::PH_COLOR;
          r.status = stxrx_pkg::ST_RESTART;
        end else if (is_end) begin
          rx_phase = stxrx_pkg::PH_HUNT;
          r.status = stxrx_pkg::ST_ABORT;
        end else begin
          r.status = stxrx_pkg::ST_CHAR;
          r.char_write = 1'b1;
          r.line_number = line_cnt;
          r.char_position = pos_cnt;
          r.char_value = b;
          if (int'(pos_cnt) + 1 >= CHARS_PER_LINE) begin
            pos_cnt = '0;
            if (int'(line_cnt) + 1 >= LINES) begin
              line_cnt = '0;
              rx_phase = stxrx_pkg::PH_TERM;
            end else begin
              line_cnt = line_cnt + 2'd1;
            end
          end else begin
            pos_cnt = pos_cnt + 4'd1;
          end
        end
      end
      default: begin
        if (is_start) begin
          rx_phase = stxrx_pkg::PH_COLOR;
          r.status = stxrx_pkg::ST_RESTART;
        end else if (is_end) begin
          rx_phase = stxrx_pkg::PH_HUNT;
          r.status = stxrx_pkg::ST_DONE;
        end else begin
          rx_phase = stxrx_pkg::PH_HUNT;
          r.status = stxrx_pkg::ST_DROP;
        end
      end
    endcase
    r.text_color = color_hold;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // sender
  always @(posedge clk) begin
    if (rst) begin
      rx_valid <= 1'b0;
    end else begin
      if (rx_valid && !rx_stall) begin
        expected_results.push_back(decode_byte(rx_byte));
      end
      if (rx_valid && rx_stall) begin
        // hold the stalled transaction
      end else if (tx_gap > 0) begin
        rx_valid <= 1'b0;
        tx_gap = tx_gap - 1;
      end else if (rx_bytes_pending.size() > 0) begin
        rx_byte <= rx_bytes_pending.pop_front();
        rx_valid <= 1'b1;
        if (tx_burst > 0) begin
          tx_burst = tx_burst - 1;
          tx_gap = 0;
        end else begin
          tx_gap = pick_gap();
          if ($urandom_range(0, 39) == 0) tx_burst = $urandom_range(20, 80);
        end
      end else begin
        rx_valid <= 1'b0;
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      got_res = {status, char_write, line_number, char_position, char_value, text_color};
      if (expected_results.size() == 0) begin
        errors = errors + 1;
        if (errors <= MAX_REPORTS) begin
          $display("unexpected result transaction: status %0d char_write %0d",
                   got_res.status, got_res.char_write);
        end
      end else begin
        want_res = expected_results.pop_front();
        if (got_res.status !== want_res.status ||
            got_res.char_write !== want_res.char_write ||
            got_res.line_number !== want_res.line_number ||
            got_res.char_position !== want_res.char_position ||
            got_res.char_value !== want_res.char_value ||
            got_res.text_color !== want_res.text_color) begin
          errors = errors + 1;
          if (errors <= MAX_REPORTS) begin
            $display("mismatch exp: st %0d wr %0d ln %0d pos %0d val %h col %h",
                     want_res.status, want_res.char_write, want_res.line_number,
                     want_res.char_position, want_res.char_value, want_res.text_color);
            $display("         got: st %0d wr %0d ln %0d pos %0d val %h col %h",
                     got_res.status, got_res.char_write, got_res.line_number,
                     got_res.char_position, got_res.char_value, got_res.text_color);
          end
        end
      end
    end
    if (hold_left > 0) begin
      res_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else if (hold_served != hold_requests) begin
      hold_served = hold_served + 1;
      hold_left = LONG_HOLD_CYCLES;
      res_stall <= 1'b1;
    end else if (rx_gap > 0) begin
      res_stall <= 1'b1;
      rx_gap = rx_gap - 1;
    end else begin
      res_stall <= 1'b0;
      if (rx_burst > 0) begin
        rx_burst = rx_burst - 1;
      end else begin
        rx_gap = pick_gap();
        if ($urandom_range(0, 39) == 0) rx_burst = $urandom_range(20, 80);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (rx_valid && !rx_stall) || (res_valid && !res_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic reg_write(input logic idx, input logic [7:0] code);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= ($urandom() & 32'hFFFF_FF00) | 32'(code);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == stxrx_pkg::REG_START) cur_start = code;
    else cur_end = code;
  endtask

  task automatic set_codes(input logic [7:0] s, input logic [7:0] e);
    reg_write(stxrx_pkg::REG_START, s);
    reg_write(stxrx_pkg::REG_END, e);
  endtask

  task automatic wait_idle();
    while (rx_bytes_pending.size() != 0 || rx_valid || expected_results.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic push_byte(input logic [7:0] b);
    rx_bytes_pending.push_back(b);
    phase_items = phase_items + 1;
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    b = 8'($urandom());
    while (b == cur_start || b == cur_end) b = 8'($urandom());
    return b;
  endfunction

  task automatic push_text(input int n);
    for (int i = 0; i < n; i++) push_byte(plain_byte());
  endtask

  task automatic push_full_frame(input logic [7:0] term);
    push_byte(cur_start);
    push_byte(plain_byte());
    push_text(FRAME_CHARS);
    push_byte(term);
  endtask

  task automatic run_random(input int target);
    int kind;
    phase_items = 0;
    while (phase_items < target) begin
      kind = $urandom_range(0, 99);
      if (kind < 50) begin
        push_full_frame(cur_end);
      end else if (kind < 60) begin
        push_full_frame(plain_byte());
      end else if (kind < 67) begin
        push_full_frame(cur_start);
        push_byte(plain_byte());
        push_text(FRAME_CHARS);
        push_byte(cur_end);
      end else if (kind < 77) begin
        // abort in color or text
        push_byte(cur_start);
        if ($urandom_range(0, 3) != 0) begin
          push_byte(plain_byte());
          push_text($urandom_range(0, FRAME_CHARS - 1));
        end
        push_byte(cur_end);
      end else if (kind < 87) begin
        // restart partway, then finish
        push_byte(cur_start);
        if ($urandom_range(0, 3) != 0) begin
          push_byte(plain_byte());
          push_text($urandom_range(0, FRAME_CHARS - 1));
        end
        push_full_frame(cur_end);
      end else begin
        for (int i = $urandom_range(1, 5); i > 0; i--) push_byte(8'($urandom()));
      end
    end
  endtask

  initial begin
    logic [7:0] s;
    logic [7:0] e;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset codes: hunting noise, restarts and aborts in color and text
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(stxrx_pkg::START_CODE_RESET);
    push_byte(stxrx_pkg::START_CODE_RESET);
    push_byte(stxrx_pkg::END_CODE_RESET);
    push_byte(stxrx_pkg::START_CODE_RESET);
    push_byte(8'hFF);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'h7E);
    push_byte(stxrx_pkg::START_CODE_RESET);
    push_byte(8'h00);
    push_byte(8'h41);
    push_byte(stxrx_pkg::END_CODE_RESET);
    push_byte(8'h80);
    run_random(120);
    wait_idle();

    set_codes(8'h00, 8'hFF);
    run_random(130);
    hold_requests = hold_requests + 1;
    wait_idle();

    set_codes(8'hFF, 8'h00);
    run_random(120);
    wait_idle();

    s = 8'($urandom());
    e = 8'($urandom());
    while (e == s) e = 8'($urandom());
    set_codes(s, e);
    run_random(120);
    wait_idle();

    // equal codes: start wins
    s = 8'($urandom());
    set_codes(s, s);
    run_random(80);
    wait_idle();

    set_codes(stxrx_pkg::START_CODE_RESET, stxrx_pkg::END_CODE_RESET);
    run_random(80);
    wait_idle();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> files.f
sv/stxrx_pkg.sv
sv/stxrx_regs.sv
sv/stxrx_step.sv
sv/stx_etx_text_frame_receiver_core.sv
verif/stx_etx_text_frame_receiver_core_tb.sv
